// ===== src/sve_pkg.sv =====
// Shared types and constants for the sun vector estimator.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package sve_pkg;

   // Default widths of the panel samples and of the component fraction
   localparam int READING_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF    = 14;

   // Fixed field widths
   localparam int GAIN_BITS      = 8;
   localparam int GAIN_FRAC      = 7;
   localparam int PANEL_COUNT    = 6;
   localparam int NUM_AXES       = 3;
   localparam int COMP_BITS      = 16;
   localparam int MAG_BITS       = 14;
   localparam int THRESH_BITS    = 14;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   // Register reset values: unity gains, thresholds near 10% and 15% of full sun
   localparam logic [CSR_DATA_BITS-1:0] GAINS_RESET    = 48'h8080_8080_8080;
   localparam logic [THRESH_BITS-1:0]   SUN_MIN_RESET  = 14'd124;
   localparam logic [THRESH_BITS-1:0]   MAG_LOW_RESET  = 14'd124;
   localparam logic [THRESH_BITS-1:0]   MAG_HIGH_RESET = 14'd186;
   localparam logic [MAG_BITS-1:0]      MAG_MAX        = 14'h3FFF;

   // Panel slots in sample order
   localparam logic [2:0] PANEL_Z_PLUS  = 3'd4;
   localparam logic [2:0] PANEL_Z_MINUS = 3'd5;
   localparam logic [2:0] PANEL_LAST    = 3'd5;
   localparam logic [2:0] AXIS_LAST     = 3'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAINS     = 3'd0,
      CSR_SIX_PANEL = 3'd1,
      CSR_SUN_MIN   = 3'd2,
      CSR_MAG_LOW   = 3'd3,
      CSR_MAG_HIGH  = 3'd4
   } csr_index_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_DARK      = 2'd2
   } sun_status_type;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

endpackage

`default_nettype wire

// ===== src/sve_if.sv =====
// Valid/ready channel interfaces for panel sample and result transactions.
// Depends on sve_pkg for default and fixed field widths.
`default_nettype none

interface sve_req_if #(parameter int READING_BITS = sve_pkg::READING_BITS_DEF);
   logic                    valid;
   logic                    ready;
   logic [READING_BITS-1:0] reading_x_plus;
   logic [READING_BITS-1:0] reading_x_minus;
   logic [READING_BITS-1:0] reading_y_plus;
   logic [READING_BITS-1:0] reading_y_minus;
   logic [READING_BITS-1:0] reading_z_plus;
   logic [READING_BITS-1:0] reading_z_minus;

   modport source (output valid, output reading_x_plus, output reading_x_minus,
                   output reading_y_plus, output reading_y_minus,
                   output reading_z_plus, output reading_z_minus, input ready);
   modport sink (input valid, input reading_x_plus, input reading_x_minus,
                 input reading_y_plus, input reading_y_minus,
                 input reading_z_plus, input reading_z_minus, output ready);
endinterface

interface sve_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sve_pkg::COMP_BITS-1:0] x_comp;
   logic signed [sve_pkg::COMP_BITS-1:0] y_comp;
   logic signed [sve_pkg::COMP_BITS-1:0] z_comp;
   logic [sve_pkg::MAG_BITS-1:0]         magnitude;
   logic [sve_pkg::STATUS_BITS-1:0]      sun_status;

   modport source (output valid, output x_comp, output y_comp, output z_comp,
                   output magnitude, output sun_status, input ready);
   modport sink (input valid, input x_comp, input y_comp, input z_comp,
                 input magnitude, input sun_status, output ready);
endinterface

`default_nettype wire

// ===== src/sve_alu.sv =====
// Shared arithmetic unit: one multiplier for gains and squares, one
// compare-and-subtract for the root and divide iterations. Uses sve_pkg.
`default_nettype none

module sve_alu #(
   parameter int WIDTH = 28
) (
   input  sve_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    opa,
   input  logic [WIDTH-1:0]    opb,
   output logic [WIDTH-1:0]    result,
   output logic                ge
);
   import sve_pkg::*;

   localparam int HALF = WIDTH / 2;

   logic [WIDTH:0] diff;

   // Trial subtract; the borrow tells whether opa >= opb
   always_comb begin
      diff = {1'b0, opa} - {1'b0, opb};
      ge   = ~diff[WIDTH];
      case (op)
         ALU_MUL: result = WIDTH'(opa[HALF-1:0]) * WIDTH'(opb[HALF-1:0]);
         ALU_SUB: result = diff[WIDTH-1:0];
         default: result = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/sun_vector_estimator_core.sv =====
// Sun vector estimator: six panel samples in, unit vector, magnitude and status out.
// The shared unit sets the pace: one multiply per panel and axis, one root bit per cycle,
// one quotient bit per cycle. One transaction at a time: a new one is accepted only in idle,
// after the result has been loaded into the output register. Synchronous reset: idle, dark,
// registers at defaults.
`default_nettype none

module sun_vector_estimator_core #(
   parameter int READING_BITS        = sve_pkg::READING_BITS_DEF,
   parameter int COMPONENT_FRAC_BITS = sve_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   sve_req_if.sink                             req_chan,
   sve_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [sve_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sve_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import sve_pkg::*;

   localparam int SB       = READING_BITS + 1;       // scaled sample and difference
   localparam int RB       = SB + 1;                 // root
   localparam int W        = 2 * RB;                 // sum of squares, unit width
   localparam int F        = COMPONENT_FRAC_BITS;
   localparam int STEP_MAX = (RB > F + 1) ? RB : F + 1;
   localparam int STEP_W   = $clog2(STEP_MAX);
   localparam int CMP_W    = (RB > THRESH_BITS) ? RB : THRESH_BITS;
   localparam int CW       = (F + 2 > COMP_BITS) ? F + 2 : COMP_BITS;
   localparam logic [W-1:0] BIT_INIT = W'(1) << (W - 2);
   localparam logic [F:0]   Q_ONE    = {1'b1, {F{1'b0}}};

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCALE  = 6'b000010,
      ST_SQUARE = 6'b000100,
      ST_ROOT   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   // Control and configuration registers
   state_type                 state_ff, state_in;
   logic [2:0]                idx_ff, idx_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      lit_ff, lit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CSR_DATA_BITS-1:0]  csr_gains_ff, csr_gains_in;
   logic                      csr_six_ff, csr_six_in;
   logic [THRESH_BITS-1:0]    csr_sun_min_ff, csr_sun_min_in;
   logic [THRESH_BITS-1:0]    csr_mag_low_ff, csr_mag_low_in;
   logic [THRESH_BITS-1:0]    csr_mag_high_ff, csr_mag_high_in;

   // Datapath registers
   logic [READING_BITS-1:0]   rd_ff [PANEL_COUNT];
   logic [READING_BITS-1:0]   rd_in [PANEL_COUNT];
   logic [SB-1:0]             plus_ff, plus_in;
   logic [SB-1:0]             diff_ff [NUM_AXES];
   logic [SB-1:0]             diff_in [NUM_AXES];
   logic [NUM_AXES-1:0]       neg_ff, neg_in;
   logic                      zp_ok_ff, zp_ok_in;
   logic [W-1:0]              sum_ff, sum_in;
   logic [W-1:0]              res_ff, res_in;
   logic [W-1:0]              bit_ff, bit_in;
   logic [RB-1:0]             mag_ff, mag_in;
   logic [RB:0]               r_ff, r_in;
   logic [F:0]                q_ff, q_in;
   logic [COMP_BITS-1:0]      comp_ff [NUM_AXES];
   logic [COMP_BITS-1:0]      comp_in [NUM_AXES];
   logic [COMP_BITS-1:0]      rsp_x_ff, rsp_x_in;
   logic [COMP_BITS-1:0]      rsp_y_ff, rsp_y_in;
   logic [COMP_BITS-1:0]      rsp_z_ff, rsp_z_in;
   logic [MAG_BITS-1:0]       rsp_mag_ff, rsp_mag_in;
   logic [STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;

   // Shared unit connections and helpers
   alu_op_type                alu_op;
   logic [W-1:0]              alu_a, alu_b, alu_result;
   logic                      alu_ge;
   logic                      req_fire;
   logic [GAIN_BITS-1:0]      gain;
   logic [SB-1:0]             scaled;
   logic [SB-1:0]             abs_diff;
   logic [W-1:0]              root_next;
   logic [RB:0]               r_cur;
   logic [F:0]                q_final, q_sel;
   logic signed [CW-1:0]      comp_full;
   logic [CMP_W-1:0]          mag_ext, mag_root_ext;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.x_comp     = rsp_x_ff;
   assign rsp_chan.y_comp     = rsp_y_ff;
   assign rsp_chan.z_comp     = rsp_z_ff;
   assign rsp_chan.magnitude  = rsp_mag_ff;
   assign rsp_chan.sun_status = rsp_status_ff;

   // Configuration writes; unknown indexes are dropped
   always_comb begin
      csr_gains_in    = csr_gains_ff;
      csr_six_in      = csr_six_ff;
      csr_sun_min_in  = csr_sun_min_ff;
      csr_mag_low_in  = csr_mag_low_ff;
      csr_mag_high_in = csr_mag_high_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GAINS:     csr_gains_in    = csr_write_data;
            CSR_SIX_PANEL: csr_six_in      = csr_write_data[0];
            CSR_SUN_MIN:   csr_sun_min_in  = csr_write_data[THRESH_BITS-1:0];
            CSR_MAG_LOW:   csr_mag_low_in  = csr_write_data[THRESH_BITS-1:0];
            CSR_MAG_HIGH:  csr_mag_high_in = csr_write_data[THRESH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared unit
   always_comb begin
      gain  = csr_gains_ff[{idx_ff, 3'b000} +: GAIN_BITS];
      r_cur = (step_ff == '0) ? {2'b00, diff_ff[idx_ff[1:0]]} : {r_ff[RB-1:0], 1'b0};
      alu_op = ALU_MUL;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         ST_SCALE: begin
            alu_op = ALU_MUL;
            alu_a  = W'(rd_ff[idx_ff]);
            alu_b  = W'(gain);
         end
         ST_SQUARE: begin
            alu_op = ALU_MUL;
            alu_a  = W'(diff_ff[idx_ff[1:0]]);
            alu_b  = W'(diff_ff[idx_ff[1:0]]);
         end
         ST_ROOT: begin
            alu_op = ALU_SUB;
            alu_a  = sum_ff;
            alu_b  = res_ff | bit_ff;
         end
         ST_DIVIDE: begin
            alu_op = ALU_SUB;
            alu_a  = W'(r_cur);
            alu_b  = W'(mag_ff);
         end
         default: ;
      endcase
   end

   sve_alu #(.WIDTH(W)) u_alu (
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_result),
      .ge     (alu_ge)
   );

   // Scaled panel value, absolute difference, root step and quotient shaping
   always_comb begin
      scaled = alu_result[GAIN_FRAC +: SB];
      if (idx_ff == PANEL_Z_MINUS && !csr_six_ff) begin
         scaled = '0;
      end
      abs_diff     = (plus_ff >= scaled) ? plus_ff - scaled : scaled - plus_ff;
      root_next    = alu_ge ? ((res_ff >> 1) | bit_ff) : (res_ff >> 1);
      mag_root_ext = CMP_W'(root_next[RB-1:0]);
      mag_ext      = CMP_W'(mag_ff);
      q_final      = {q_ff[F-1:0], alu_ge};
      q_sel        = (q_final > Q_ONE) ? Q_ONE : q_final;
      if (mag_ff == '0) begin
         comp_full = '0;
      end else if (neg_ff[idx_ff[1:0]]) begin
         comp_full = -$signed(CW'(q_sel));
      end else begin
         comp_full = $signed(CW'(q_sel));
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      lit_in        = lit_ff;
      rd_in         = rd_ff;
      plus_in       = plus_ff;
      diff_in       = diff_ff;
      neg_in        = neg_ff;
      zp_ok_in      = zp_ok_ff;
      sum_in        = sum_ff;
      res_in        = res_ff;
      bit_in        = bit_ff;
      mag_in        = mag_ff;
      r_in          = r_ff;
      q_in          = q_ff;
      comp_in       = comp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_mag_in    = rsp_mag_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_in[0] = req_chan.reading_x_plus;
               rd_in[1] = req_chan.reading_x_minus;
               rd_in[2] = req_chan.reading_y_plus;
               rd_in[3] = req_chan.reading_y_minus;
               rd_in[4] = req_chan.reading_z_plus;
               rd_in[5] = req_chan.reading_z_minus;
               idx_in   = '0;
               sum_in   = '0;
               res_in   = '0;
               bit_in   = BIT_INIT;
               state_in = ST_SCALE;
            end
         end
         // One panel per cycle; pair each minus panel with its plus panel
         ST_SCALE: begin
            if (!idx_ff[0]) begin
               plus_in = scaled;
            end else begin
               diff_in[idx_ff[2:1]] = abs_diff;
               neg_in[idx_ff[2:1]]  = scaled > plus_ff;
            end
            if (idx_ff == PANEL_Z_PLUS) begin
               zp_ok_in = csr_six_ff || (CMP_W'(scaled) >= CMP_W'(csr_sun_min_ff));
            end
            if (idx_ff == PANEL_LAST) begin
               idx_in   = '0;
               state_in = ST_SQUARE;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         // Accumulate the sum of squares
         ST_SQUARE: begin
            sum_in = sum_ff + alu_result;
            if (idx_ff == AXIS_LAST) begin
               step_in  = '0;
               state_in = ST_ROOT;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         // One root bit per cycle, then update the lit/dark hysteresis
         ST_ROOT: begin
            if (alu_ge) begin
               sum_in = alu_result;
            end
            res_in = root_next;
            bit_in = bit_ff >> 2;
            if (step_ff == STEP_W'(RB - 1)) begin
               mag_in = root_next[RB-1:0];
               if (lit_ff && mag_root_ext < CMP_W'(csr_mag_low_ff)) begin
                  lit_in = 1'b0;
               end else if (!lit_ff && mag_root_ext > CMP_W'(csr_mag_high_ff)) begin
                  lit_in = 1'b1;
               end
               step_in  = '0;
               idx_in   = '0;
               state_in = ST_DIVIDE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         // One quotient bit per cycle, one axis after another
         ST_DIVIDE: begin
            r_in = alu_ge ? alu_result[RB:0] : r_cur;
            q_in = q_final;
            if (step_ff == STEP_W'(F)) begin
               comp_in[idx_ff[1:0]] = comp_full[COMP_BITS-1:0];
               step_in = '0;
               if (idx_ff == AXIS_LAST) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         // Load the output register once the previous transaction has left
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = comp_ff[0];
               rsp_y_in     = comp_ff[1];
               rsp_z_in     = comp_ff[2];
               rsp_mag_in   = (mag_ext > CMP_W'(MAG_MAX)) ? MAG_MAX : mag_ext[MAG_BITS-1:0];
               if (!lit_ff) begin
                  rsp_status_in = STATUS_DARK;
               end else if (zp_ok_ff) begin
                  rsp_status_in = STATUS_FOUND;
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         idx_ff          <= '0;
         step_ff         <= '0;
         lit_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         csr_gains_ff    <= GAINS_RESET;
         csr_six_ff      <= 1'b1;
         csr_sun_min_ff  <= SUN_MIN_RESET;
         csr_mag_low_ff  <= MAG_LOW_RESET;
         csr_mag_high_ff <= MAG_HIGH_RESET;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         step_ff         <= step_in;
         lit_ff          <= lit_in;
         rsp_valid_ff    <= rsp_valid_in;
         csr_gains_ff    <= csr_gains_in;
         csr_six_ff      <= csr_six_in;
         csr_sun_min_ff  <= csr_sun_min_in;
         csr_mag_low_ff  <= csr_mag_low_in;
         csr_mag_high_ff <= csr_mag_high_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_ff         <= rd_in;
      plus_ff       <= plus_in;
      diff_ff       <= diff_in;
      neg_ff        <= neg_in;
      zp_ok_ff      <= zp_ok_in;
      sum_ff        <= sum_in;
      res_ff        <= res_in;
      bit_ff        <= bit_in;
      mag_ff        <= mag_in;
      r_ff          <= r_in;
      q_ff          <= q_in;
      comp_ff       <= comp_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_mag_ff    <= rsp_mag_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef NO_ASSERTIONS
   // An accepted transaction starts the gain pass
   a_start_scale: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_SCALE)
      else $error("accepted transaction did not start scaling");

   // The divide remainder stays below a nonzero magnitude
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && (step_ff != '0) && (mag_ff != '0) |-> r_ff < {1'b0, mag_ff})
      else $error("divide remainder not below magnitude");

   // A finished transaction with a free output register is shown next cycle
   a_finish_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished result not loaded into output register");
`endif

endmodule

`default_nettype wire
